// ----- hdl/bfm_pkg.sv -----
// Shared types, constants and helpers for the bytebeat formula mixer.
// No dependencies; every other file in hdl/ imports this package.
package bfm_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned CHOICE_W     = 3;
    localparam int unsigned CARD_ID_W    = 56;
    localparam int unsigned CARD_LEN_W   = 3;
    localparam int unsigned CFG_ADDR_W   = 1;
    localparam int unsigned MAX_ID_BYTES = 7;
    localparam int unsigned DIV_STAGES   = DATA_W;
    localparam int unsigned BANK_STAGES  = 3;
    localparam int unsigned ALIGN_STAGES = DIV_STAGES - BANK_STAGES;
    localparam int unsigned S_TDATA_W    = 32;
    localparam int unsigned M_TDATA_W    = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_CARD_ID     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CARD_ID_LEN = 1'b1;

    localparam logic [CHOICE_W-1:0] FORMULA_0 = 3'd0;
    localparam logic [CHOICE_W-1:0] FORMULA_1 = 3'd1;
    localparam logic [CHOICE_W-1:0] FORMULA_2 = 3'd2;
    localparam logic [CHOICE_W-1:0] FORMULA_3 = 3'd3;
    localparam logic [CHOICE_W-1:0] FORMULA_4 = 3'd4;
    localparam logic [CHOICE_W-1:0] FORMULA_5 = 3'd5;

    typedef logic [DATA_W-1:0]   word_t;
    typedef logic [CHOICE_W-1:0] choice_t;

    // Since 8 is 1 modulo 7, octal digits are folded until the value is below 7.
    function automatic choice_t mod7(input logic [7:0] x);
        logic [4:0] y;
        logic [3:0] z;
        y = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[7:6]);
        z = 4'(y[2:0]) + 4'(y[4:3]);
        if (z >= 4'd7) begin
            z = z - 4'd7;
        end
        return z[2:0];
    endfunction

endpackage

// ----- hdl/bfm_divider.sv -----
// Pipelined restoring remainder unit for t mod ((t >> 13) & (t >> 6)).
// One quotient bit per stage; a zero divisor yields a zero remainder. Uses bfm_pkg.
module bfm_divider import bfm_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  word_t t,
    output word_t rem
);

    word_t num_reg [DIV_STAGES];
    word_t den_reg [DIV_STAGES];
    word_t rem_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        word_t          num_in;
        word_t          den_in;
        word_t          rem_in;
        logic [DATA_W:0] shifted;
        word_t          rem_next;

        if (k == 0) begin : g_first
            assign num_in = t;
            assign den_in = (t >> 13) & (t >> 6);
            assign rem_in = '0;
        end else begin : g_rest
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign rem_in = rem_reg[k-1];
        end

        always_comb begin
            shifted = {rem_in, num_in[DATA_W-1-k]};
            if (shifted >= {1'b0, den_in}) begin
                rem_next = DATA_W'(shifted - {1'b0, den_in});
            end else begin
                rem_next = shifted[DATA_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= num_in;
                den_reg[k] <= den_in;
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign rem = (den_reg[DIV_STAGES-1] == '0) ? '0 : rem_reg[DIV_STAGES-1];

endmodule

// ----- hdl/bfm_bank1.sv -----
// First formula bank: operand select, shared multiplier, result select.
// Three register stages. Uses bfm_pkg.
module bfm_bank1 import bfm_pkg::*; (
    input  logic    aclk,
    input  logic    en,
    input  choice_t sel,
    input  word_t   t,
    output word_t   value
);

    word_t t2, t3, t5, x, b_next, nm_next;
    word_t a_reg, b_reg, nm_reg, p_reg, nm2_reg, res_reg;
    word_t p_next, res_next;

    assign t2 = t << 1;
    assign t3 = t2 + t;
    assign t5 = (t << 2) + t;
    assign x  = (t & (t2 >> 16)) | (t & (t2 >> 8));

    always_comb begin
        b_next  = '0;
        nm_next = '0;
        case (sel)
            FORMULA_0: nm_next = (t & (t >> 6)) | ((t >> 2) & 32'hFF);
            FORMULA_1: nm_next = t2 & (((t >> 4) | (t >> 14)) & 32'h7F);
            FORMULA_2: b_next  = ((t >> 3) | (t >> 9)) & 32'h40 & (t >> 2);
            FORMULA_3: nm_next = (t5 & (t >> 7)) | (t3 & (t >> 10));
            FORMULA_4: nm_next = (x << 1) & 32'h7F;
            FORMULA_5: b_next  = (t >> 12) | (t >> 6);
            default:   b_next  = (t3 >> 4) | (t2 >> 10);
        endcase
    end

    assign p_next = a_reg * b_reg;

    always_comb begin
        case (sel)
            FORMULA_2: res_next = p_reg;
            FORMULA_5: res_next = (p_reg & 32'h20) << 1;
            FORMULA_0, FORMULA_1, FORMULA_3, FORMULA_4: res_next = nm2_reg;
            default:   res_next = (p_reg & 32'h20) << 1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= t;
            b_reg   <= b_next;
            nm_reg  <= nm_next;
            p_reg   <= p_next;
            nm2_reg <= nm_reg;
            res_reg <= res_next;
        end
    end

    assign value = res_reg;

endmodule

// ----- hdl/bfm_bank2.sv -----
// Second formula bank except the modulo formula, which bfm_divider serves.
// Three register stages around one shared multiplier. Uses bfm_pkg.
module bfm_bank2 import bfm_pkg::*; (
    input  logic    aclk,
    input  logic    en,
    input  choice_t sel,
    input  word_t   t,
    output word_t   value
);

    word_t a_next, b_next, m_next;
    word_t a_reg, b_reg, m_reg, p_reg, m2_reg, res_reg;
    word_t p_next, res_next;

    always_comb begin
        a_next = t;
        b_next = '0;
        m_next = '0;
        case (sel)
            FORMULA_0: b_next = '0;
            FORMULA_1: begin
                b_next = t;
                m_next = t >> ((t >> 10) & 32'hF);
            end
            FORMULA_2: begin
                b_next = t;
                m_next = t >> ((t >> 8) & 32'hF);
            end
            FORMULA_3: b_next = (t >> 10) | (t >> 5);
            FORMULA_4: begin
                a_next = t << 1;
                b_next = (t >> 14) | (t >> 12);
            end
            FORMULA_5: b_next = (t >> 9) | (t >> 13);
            default:   b_next = (t >> 14) | (t >> 10);
        endcase
    end

    assign p_next = a_reg * b_reg;

    always_comb begin
        case (sel)
            FORMULA_0: res_next = '0;
            FORMULA_1: res_next = (p_reg >> 8) & m2_reg;
            FORMULA_2: res_next = (p_reg >> 7) & m2_reg;
            FORMULA_3, FORMULA_4, FORMULA_5: res_next = (p_reg & 32'h10) << 1;
            default:   res_next = (p_reg & 32'h8) << 3;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            m_reg   <= m_next;
            p_reg   <= p_next;
            m2_reg  <= m_reg;
            res_reg <= res_next;
        end
    end

    assign value = res_reg;

endmodule

// ----- hdl/bytebeat_formula_mixer_unit.sv -----
// Top level of the bytebeat formula mixer: configuration, choice logic,
// formula pipelines and output register. Uses bfm_pkg, bfm_divider, bfm_bank1, bfm_bank2.
//
//   channel   direction  payload (lowest bit first)
//   s_*       in         tdata: time_index[31:0]
//   m_*       out        tdata: sample[31:0], first_choice[34:32], second_choice[37:35]
//   cfg_*     in         index 0 card_id, index 1 card_id_length
//
// One word per cycle is accepted while the output is not stalled; a sample passes through the input
// register, the remainder unit stages and the output register, the remainder unit setting the depth.
// Reset is synchronous, clears the valid bits and card_id, and sets card_id_length to 4; no clearing pass.
// A stalled output freezes the whole pipeline and drops s_tready; nothing is lost.
module bytebeat_formula_mixer_unit import bfm_pkg::*; #(
    parameter int unsigned MAX_BYTES = MAX_ID_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // time_index
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // sample, first_choice, second_choice
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CARD_ID_W-1:0]  cfg_wdata
);

    logic [CARD_ID_W-1:0]  card_id_reg;
    logic [CARD_LEN_W-1:0] card_len_reg;
    choice_t               c1_reg, c2_reg, c1_next, c2_next;
    logic [7:0]            hi_sum, lo_sum, id_byte;

    logic                  en;
    logic [DIV_STAGES:0]   vld_reg;
    word_t                 t_reg;
    word_t                 b1_val, b2_val, rem;
    word_t                 b1_dly_reg [ALIGN_STAGES];
    word_t                 b2_dly_reg [ALIGN_STAGES];
    word_t                 b2_final, sample_next;
    word_t                 out_sample_reg;
    choice_t               out_c1_reg, out_c2_reg;
    logic                  out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            card_id_reg  <= '0;
            card_len_reg <= CARD_LEN_W'(4);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CARD_ID:     card_id_reg  <= cfg_wdata;
                REG_CARD_ID_LEN: card_len_reg <= cfg_wdata[CARD_LEN_W-1:0];
                default:         card_id_reg  <= card_id_reg;
            endcase
        end
    end

    always_comb begin
        hi_sum = '0;
        lo_sum = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            id_byte = 8'(card_id_reg >> (8 * (MAX_BYTES - 1 - i)));
            if (i < int'(card_len_reg)) begin
                hi_sum = hi_sum + 8'(id_byte[7:4]);
                lo_sum = lo_sum + 8'(id_byte[3:0]);
            end
        end
        c1_next = mod7(hi_sum);
        c2_next = mod7(lo_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
        end else begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
        end
    end

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[DIV_STAGES-1:0], s_tvalid};
            out_vld_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= s_tdata[DATA_W-1:0];
        end
    end

    bfm_divider u_div (.aclk(aclk), .en(en), .t(t_reg), .rem(rem));
    bfm_bank1 u_bank1 (.aclk(aclk), .en(en), .sel(c1_reg), .t(t_reg), .value(b1_val));
    bfm_bank2 u_bank2 (.aclk(aclk), .en(en), .sel(c2_reg), .t(t_reg), .value(b2_val));

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_dly_reg[0] <= b1_val;
            b2_dly_reg[0] <= b2_val;
            for (int k = 1; k < ALIGN_STAGES; k++) begin
                b1_dly_reg[k] <= b1_dly_reg[k-1];
                b2_dly_reg[k] <= b2_dly_reg[k-1];
            end
        end
    end

    assign b2_final    = (c2_reg == FORMULA_0) ? (rem << 3) - rem
                                               : b2_dly_reg[ALIGN_STAGES-1];
    assign sample_next = b1_dly_reg[ALIGN_STAGES-1] + b2_final;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_sample_reg <= sample_next;
            out_c1_reg     <= c1_reg;
            out_c2_reg     <= c2_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_c2_reg, out_c1_reg, out_sample_reg};

    a_choice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_c1_reg != 3'd7) && (out_c2_reg != 3'd7))
        else $error("formula choice out of range");

    a_pipe_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[DIV_STAGES] && en) |=> m_tvalid)
        else $error("word lost at the output stage");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en) |=> $stable(out_sample_reg) && $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
